### rtl/lrt_pkg.sv
// Shared types, constants and helpers for the longest-prefix-match route table.
package lrt_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int PORT_W = 3;
    localparam int TTL_W  = 8;

    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DEF_NUM_PORTS   = 8;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

    typedef enum logic [0:0] {
        FN_ADD   = 1'b0,
        FN_ROUTE = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        ST_ADDED       = 3'd0,
        ST_FORWARDED   = 3'd1,
        ST_TTL_EXPIRED = 3'd2,
        ST_NO_ROUTE    = 3'd3,
        ST_TABLE_FULL  = 3'd4
    } status_t;

    typedef struct packed {
        logic [0:0]        func;
        logic [ADDR_W-1:0] add_prefix;
        logic [LEN_W-1:0]  prefix_len;
        logic              hop_given;
        logic [ADDR_W-1:0] hop_addr;
        logic [PORT_W-1:0] port_sel;
        logic [ADDR_W-1:0] dest_addr;
        logic [TTL_W-1:0]  ttl_in;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [PORT_W-1:0] out_port;
        logic [ADDR_W-1:0] fwd_hop;
        logic [TTL_W-1:0]  ttl_out;
    } rsp_t;

    // One stored route
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic              hop_given;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
    } entry_t;

    // Compare unit result
    typedef struct packed {
        logic hit;
        logic longer;
    } cmp_t;

    // High-bit mask; length 0 gives zero, 32 gives all ones
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        len_mask = ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

### rtl/lrt_req_if.sv
// Request channel: valid/ready handshake carrying one table request.
interface lrt_req_if;
    logic          valid;
    logic          ready;
    lrt_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/lrt_rsp_if.sv
// Response channel: valid/ready handshake carrying one table result.
interface lrt_rsp_if;
    logic          valid;
    logic          ready;
    lrt_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/lrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lrt_cmp.sv
// Shared entry compare unit: exact match for adds, masked match for lookups.
module lrt_cmp (
    input  logic                         func,
    input  logic [lrt_pkg::ADDR_W-1:0]   key,
    input  logic [lrt_pkg::LEN_W-1:0]    key_len,
    input  lrt_pkg::entry_t              ent,
    input  logic [lrt_pkg::LEN_W-1:0]    best_len,
    output lrt_pkg::cmp_t                res
);

    logic exact_hit;
    logic masked_hit;

    assign exact_hit  = (ent.prefix == key) && (ent.len == key_len);
    assign masked_hit = ((key & lrt_pkg::len_mask(ent.len)) == ent.prefix);

    always_comb
    begin
        res.hit    = (func == lrt_pkg::FN_ROUTE) ? masked_hit : exact_hit;
        res.longer = (ent.len > best_len);
    end

endmodule

### rtl/lpm_route_table.sv
// Top level: IPv4 longest-prefix-match forwarding table with a scanning sequencer.
//
//  channel | dir | payload                                         | handshake
//  --------+-----+-------------------------------------------------+-----------
//  req     | in  | func, add_prefix, prefix_len, hop_given,        | valid/ready
//          |     | hop_addr, port_sel, dest_addr, ttl_in           |
//  rsp     | out | status, out_port, fwd_hop, ttl_out              | valid/ready
//
// Scan: one table entry per cycle through the RAM read port and the shared
//   compare unit, over every stored route; the result then enters the output
//   register and req.ready returns as it does, so no new request is taken
//   until the last one is through. A lookup with TTL of 0 or 1 skips the scan
//   and goes straight to the done state.
// Reset: clears the sequencer, the fill count and the result valid. Routes
//   fill from entry 0 upward and are never removed, so entry i is valid
//   exactly when i < fill count; no clearing pass is needed.
// Stalls: req.ready is high only while the sequencer is idle. A finished result
//   sits in the output register; the next request may be taken meanwhile and
//   holds in its final state until that register frees up.
module lpm_route_table #(
    parameter int TABLE_DEPTH = lrt_pkg::DEF_TABLE_DEPTH,
    parameter int NUM_PORTS   = lrt_pkg::DEF_NUM_PORTS
) (
    input  logic      clk,
    input  logic      rst_n,
    lrt_req_if.sink   req,
    lrt_rsp_if.source rsp
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                       state_reg, state_next;

    // Request context held for the whole scan
    logic                         func_reg, func_next;
    logic [lrt_pkg::ADDR_W-1:0]   key_reg, key_next;
    logic [lrt_pkg::LEN_W-1:0]    len_reg, len_next;
    logic                         hop_given_reg, hop_given_next;
    logic [lrt_pkg::ADDR_W-1:0]   hop_reg, hop_next;
    logic [lrt_pkg::PORT_W-1:0]   port_reg, port_next;
    logic [lrt_pkg::TTL_W-1:0]    ttl_reg, ttl_next;
    logic                         expired_reg, expired_next;

    // Scan bookkeeping
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                iss_reg, iss_next;
    logic                         pend_reg, pend_next;
    logic [AW-1:0]                pidx_reg, pidx_next;
    logic                         found_reg, found_next;
    logic [AW-1:0]                hit_idx_reg, hit_idx_next;
    lrt_pkg::entry_t              best_reg, best_next;

    // Output register
    logic                         rsp_valid_reg, rsp_valid_next;
    lrt_pkg::rsp_t                rsp_data_reg, rsp_data_next;

    // RAM and compare unit
    logic                         rd_en;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    lrt_pkg::entry_t              wr_data;
    lrt_pkg::entry_t              rd_data;
    lrt_pkg::cmp_t                cmp_res;

    // Request decode helpers
    logic [lrt_pkg::LEN_W-1:0]    clamp_len;
    logic [lrt_pkg::PORT_W-1:0]   sat_port;
    logic                         accept;
    logic                         out_free;

    assign accept   = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;

    assign clamp_len = (req.data.prefix_len > lrt_pkg::MAX_LEN) ? lrt_pkg::MAX_LEN
                                                                : req.data.prefix_len;
    assign sat_port  = ({29'd0, req.data.port_sel} >= 32'(NUM_PORTS))
                       ? lrt_pkg::PORT_W'(NUM_PORTS - 1) : req.data.port_sel;

    assign rd_en = (state_reg == S_SCAN) && (iss_reg < count_reg);

    lrt_ram #(
        .WIDTH ($bits(lrt_pkg::entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (iss_reg[AW-1:0]),
        .rdata (rd_data)
    );

    lrt_cmp u_cmp (
        .func     (func_reg),
        .key      (key_reg),
        .key_len  (len_reg),
        .ent      (rd_data),
        .best_len (best_reg.len),
        .res      (cmp_res)
    );

    always_comb
    begin
        wr_data.prefix    = key_reg;
        wr_data.len       = len_reg;
        wr_data.hop_given = hop_given_reg;
        wr_data.hop       = hop_reg;
        wr_data.port      = port_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        hop_given_next = hop_given_reg;
        hop_next       = hop_reg;
        port_next      = port_reg;
        ttl_next       = ttl_reg;
        expired_next   = expired_reg;
        count_next     = count_reg;
        iss_next       = iss_reg;
        pend_next      = 1'b0;
        pidx_next      = iss_reg[AW-1:0];
        found_next     = found_reg;
        hit_idx_next   = hit_idx_reg;
        best_next      = best_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        wr_en          = 1'b0;
        wr_addr        = hit_idx_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next      = req.data.func;
                    len_next       = clamp_len;
                    hop_given_next = req.data.hop_given;
                    hop_next       = req.data.hop_addr;
                    port_next      = sat_port;
                    ttl_next       = req.data.ttl_in - lrt_pkg::TTL_W'(1);
                    iss_next       = '0;
                    found_next     = 1'b0;
                    best_next      = '0;
                    if (req.data.func == lrt_pkg::FN_ROUTE)
                    begin
                        key_next = req.data.dest_addr;
                    end
                    else
                    begin
                        key_next = req.data.add_prefix & lrt_pkg::len_mask(clamp_len);
                    end
                    // TTL 0 or 1 dies here; no scan
                    expired_next = (req.data.func == lrt_pkg::FN_ROUTE)
                                   && (req.data.ttl_in <= lrt_pkg::TTL_W'(1));
                    state_next   = expired_next ? S_DONE : S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (rd_en)
                begin
                    iss_next  = iss_reg + CW'(1);
                    pend_next = 1'b1;
                end
                // Entry read last cycle is on rd_data now
                if (pend_reg && cmp_res.hit)
                begin
                    if (func_reg == lrt_pkg::FN_ROUTE)
                    begin
                        if (!found_reg || cmp_res.longer)
                        begin
                            found_next = 1'b1;
                            best_next  = rd_data;
                        end
                    end
                    else if (!found_reg)
                    begin
                        found_next   = 1'b1;
                        hit_idx_next = pidx_reg;
                    end
                end
                if (!rd_en && !pend_reg)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = '0;
                    state_next     = S_IDLE;
                    if (expired_reg)
                    begin
                        rsp_data_next.status = lrt_pkg::ST_TTL_EXPIRED;
                    end
                    else if (func_reg == lrt_pkg::FN_ROUTE)
                    begin
                        if (found_reg)
                        begin
                            rsp_data_next.status   = lrt_pkg::ST_FORWARDED;
                            rsp_data_next.out_port = best_reg.port;
                            rsp_data_next.fwd_hop  = best_reg.hop_given ? best_reg.hop
                                                                        : key_reg;
                            rsp_data_next.ttl_out  = ttl_reg;
                        end
                        else
                        begin
                            rsp_data_next.status = lrt_pkg::ST_NO_ROUTE;
                        end
                    end
                    else if (found_reg)
                    begin
                        // Same prefix and length: overwrite in place
                        wr_en                = 1'b1;
                        wr_addr              = hit_idx_reg;
                        rsp_data_next.status = lrt_pkg::ST_ADDED;
                    end
                    else if (count_reg < CW'(TABLE_DEPTH))
                    begin
                        wr_en                = 1'b1;
                        wr_addr              = count_reg[AW-1:0];
                        count_next           = count_reg + CW'(1);
                        rsp_data_next.status = lrt_pkg::ST_ADDED;
                    end
                    else
                    begin
                        rsp_data_next.status = lrt_pkg::ST_TABLE_FULL;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            expired_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            expired_reg   <= expired_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        key_reg       <= key_next;
        len_reg       <= len_next;
        hop_given_reg <= hop_given_next;
        hop_reg       <= hop_next;
        port_reg      <= port_next;
        ttl_reg       <= ttl_next;
        iss_reg       <= iss_next;
        pidx_reg      <= pidx_next;
        hit_idx_reg   <= hit_idx_next;
        best_reg      <= best_next;
        rsp_data_reg  <= rsp_data_next;
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // Fill count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("route count above table depth");

    // Fill count only grows, one route at a time
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CW'(1)))
        else $error("route count jumped");

    // A taken request always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("request taken but sequencer idle");

    // A forwarded datagram never carries a dead TTL
    a_fwd_ttl: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.data.status == lrt_pkg::ST_FORWARDED))
        |-> (rsp.data.ttl_out != '0))
        else $error("forwarded with zero TTL");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

endmodule

### tb/lpm_route_table_test.sv
// Self-checking testbench for the longest-prefix-match route table: directed and random requests.
module lpm_route_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH           = lrt_pkg::DEF_TABLE_DEPTH;
    localparam int PORTS           = lrt_pkg::DEF_NUM_PORTS;
    localparam int AW              = lrt_pkg::ADDR_W;
    localparam int CLK_HALF        = 10;
    localparam int MAX_GAP         = 12;
    // Worst case per request: a scan of every filled entry plus overhead
    localparam int SCAN_CYCLES     = DEPTH + 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS    = 460;
    localparam int TIMEOUT_CYCLES  = 500_000;

    typedef struct {
        logic [AW-1:0] prefix;
        int unsigned   len;
    } route_key_t;

    logic clk = 1'b0;
    logic rst_n;

    lrt_req_if req_ch ();
    lrt_rsp_if rsp_ch ();

    lpm_route_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the forwarding table
    logic                       tbl_valid     [DEPTH];
    logic [AW-1:0]              tbl_prefix    [DEPTH];
    int unsigned                tbl_len       [DEPTH];
    logic                       tbl_hop_given [DEPTH];
    logic [AW-1:0]              tbl_hop       [DEPTH];
    logic [lrt_pkg::PORT_W-1:0] tbl_port      [DEPTH];

    lrt_pkg::rsp_t pending_results [$];  // expected responses, oldest first
    route_key_t    known_routes [$];     // routes stored so far, for targeted lookups

    int  mismatches;
    int  requests_sent;
    int  status_seen [5];
    bit  no_idle;       // both sides run back to back while set
    bit  hold_off_req;  // asks the response side for one long stall

    // Clock: 20 ns period
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // High-bit mask for a prefix length already clamped to 0..32
    function automatic logic [AW-1:0] prefix_mask(input int unsigned len);
        if (len == 0)
            return '0;
        return {AW{1'b1}} << (AW - len);
    endfunction

    // Computes the response to one request and updates the shadow table.
    function automatic lrt_pkg::rsp_t compute_route_result(input lrt_pkg::req_t r);
        lrt_pkg::rsp_t              res;
        int                         slot;
        int                         free_slot;
        int                         best;
        int unsigned                len;
        logic [AW-1:0]              pfx;
        logic [lrt_pkg::PORT_W-1:0] p;
        route_key_t                 key;

        res = '0;
        res.status = lrt_pkg::ST_ADDED;
        if (r.func == lrt_pkg::FN_ADD)
        begin
            len = r.prefix_len;
            if (len > AW)
                len = AW;
            pfx = r.add_prefix & prefix_mask(len);
            slot = -1;
            free_slot = -1;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (tbl_valid[i])
                begin
                    if (slot < 0 && tbl_prefix[i] == pfx && tbl_len[i] == len)
                        slot = i;
                end
                else if (free_slot < 0)
                begin
                    free_slot = i;
                end
            end
            if (slot < 0)
                slot = free_slot;
            if (slot < 0)
            begin
                res.status = lrt_pkg::ST_TABLE_FULL;
            end
            else
            begin
                p = (r.port_sel >= PORTS) ? lrt_pkg::PORT_W'(PORTS - 1) : r.port_sel;
                tbl_valid[slot]     = 1'b1;
                tbl_prefix[slot]    = pfx;
                tbl_len[slot]       = len;
                tbl_hop_given[slot] = r.hop_given;
                tbl_hop[slot]       = r.hop_addr;
                tbl_port[slot]      = p;
                key.prefix = pfx;
                key.len    = len;
                known_routes.push_back(key);
            end
        end
        else if (r.ttl_in <= 1)
        begin
            res.status = lrt_pkg::ST_TTL_EXPIRED;
        end
        else
        begin
            best = -1;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (tbl_valid[i]
                    && (r.dest_addr & prefix_mask(tbl_len[i])) == tbl_prefix[i])
                begin
                    if (best < 0 || tbl_len[i] > tbl_len[best])
                        best = i;
                end
            end
            if (best < 0)
            begin
                res.status = lrt_pkg::ST_NO_ROUTE;
            end
            else
            begin
                res.status   = lrt_pkg::ST_FORWARDED;
                res.out_port = tbl_port[best];
                res.fwd_hop  = tbl_hop_given[best] ? tbl_hop[best] : r.dest_addr;
                res.ttl_out  = r.ttl_in - 8'd1;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request builders; unused fields get random junk
    // ------------------------------------------------------------------

    function automatic lrt_pkg::req_t add_request(
        input logic [AW-1:0]              pfx,
        input logic [lrt_pkg::LEN_W-1:0]  len,
        input logic                       hop_given,
        input logic [AW-1:0]              hop,
        input logic [lrt_pkg::PORT_W-1:0] port);
        lrt_pkg::req_t r;
        r.func         = lrt_pkg::FN_ADD;
        r.add_prefix   = pfx;
        r.prefix_len   = len;
        r.hop_given    = hop_given;
        r.hop_addr     = hop;
        r.port_sel     = port;
        r.dest_addr    = $urandom;
        r.ttl_in       = lrt_pkg::TTL_W'($urandom);
        return r;
    endfunction

    function automatic lrt_pkg::req_t route_request(
        input logic [AW-1:0]             dest,
        input logic [lrt_pkg::TTL_W-1:0] ttl);
        lrt_pkg::req_t r;
        r.func         = lrt_pkg::FN_ROUTE;
        r.add_prefix   = $urandom;
        r.prefix_len   = lrt_pkg::LEN_W'($urandom);
        r.hop_given    = 1'($urandom);
        r.hop_addr     = $urandom;
        r.port_sel     = lrt_pkg::PORT_W'($urandom);
        r.dest_addr    = dest;
        r.ttl_in       = ttl;
        return r;
    endfunction

    // A few address blocks so random routes nest inside each other
    function automatic logic [AW-1:0] pick_base();
        case ($urandom_range(0, 7))
            0:       return 32'h0A00_0000;
            1:       return 32'hC0A8_0100;
            2:       return 32'hAC10_0000;
            3:       return 32'h0808_0800;
            4:       return 32'hFFFF_FF00;
            5:       return 32'h8000_0000;
            6:       return 32'h0000_0000;
            default: return 32'h7F00_0001;
        endcase
    endfunction

    // Mostly well-formed traffic: adds around the base blocks, lookups aimed
    // at stored routes; the rest is noise (odd lengths, random addresses).
    function automatic lrt_pkg::req_t random_request();
        lrt_pkg::req_t             r;
        route_key_t                key;
        logic [AW-1:0]             base;
        logic [AW-1:0]             m;
        logic [AW-1:0]             dest;
        logic [lrt_pkg::TTL_W-1:0] ttl;
        int unsigned               len;
        int                        sel;

        sel = $urandom_range(0, 9);
        if ($urandom_range(0, 9) < 4)
        begin
            base = pick_base();
            if (sel == 7)
                len = 8 * $urandom_range(0, 4);
            else if (sel == 8)
                len = $urandom_range(33, 63);  // clamps to a host route
            else
                len = $urandom_range(0, 32);
            // overwrite an existing route with new hop and port
            if (sel == 9 && known_routes.size() != 0)
            begin
                key  = known_routes[$urandom_range(0, known_routes.size() - 1)];
                base = key.prefix;
                len  = key.len;
            end
            m = prefix_mask(len > AW ? AW : len);
            r = add_request(base ^ ($urandom & ~m), lrt_pkg::LEN_W'(len), 1'($urandom),
                            $urandom, lrt_pkg::PORT_W'($urandom));
        end
        else
        begin
            dest = $urandom;
            if (sel <= 6 && known_routes.size() != 0)
            begin
                key  = known_routes[$urandom_range(0, known_routes.size() - 1)];
                m    = prefix_mask(key.len);
                dest = (key.prefix & m) | (dest & ~m);
            end
            else if (sel == 7)
            begin
                dest = pick_base() ^ AW'($urandom_range(0, 255));
            end
            case ($urandom_range(0, 9))
                0:       ttl = lrt_pkg::TTL_W'($urandom_range(0, 1));
                1:       ttl = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd2;
                default: ttl = lrt_pkg::TTL_W'($urandom_range(2, 255));
            endcase
            r = route_request(dest, ttl);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one request after a random gap, waits for the handshake and
    // queues the predicted response at the accepting edge.
    task automatic send_request(input lrt_pkg::req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.data  <= r;
        req_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        pending_results.push_back(compute_route_result(r));
        requests_sent++;
    endtask

    // Stops offering and waits until every queued response has come back,
    // then lets twice the worst-case scan time pass.
    task automatic drain_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * SCAN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Response side: random stalls, plus one long hold-off on demand
    // ------------------------------------------------------------------
    initial
    begin : rsp_sink
        int gap;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid === 1'b1 && rst_n === 1'b1));
        end
    end

    // Compares every accepted response with the oldest prediction
    always @(posedge clk)
    begin
        lrt_pkg::rsp_t got;
        lrt_pkg::rsp_t exp;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            got = rsp_ch.data;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected response, status=%0d port=%0d hop=%h ttl=%0d",
                         $time, got.status, got.out_port, got.fwd_hop, got.ttl_out);
                mismatches++;
            end
            else
            begin
                exp = pending_results.pop_front();
                if (got.status !== exp.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, exp.status, got.status);
                    mismatches++;
                end
                if (got.out_port !== exp.out_port)
                begin
                    $display("%0t: out_port mismatch, expected %0d, actual %0d",
                             $time, exp.out_port, got.out_port);
                    mismatches++;
                end
                if (got.fwd_hop !== exp.fwd_hop)
                begin
                    $display("%0t: fwd_hop mismatch, expected %h, actual %h",
                             $time, exp.fwd_hop, got.fwd_hop);
                    mismatches++;
                end
                if (got.ttl_out !== exp.ttl_out)
                begin
                    $display("%0t: ttl_out mismatch, expected %0d, actual %0d",
                             $time, exp.ttl_out, got.ttl_out);
                    mismatches++;
                end
                status_seen[int'(exp.status)]++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Lookups before any route exists: expiry wins over no-route.
    task automatic test_empty_table();
        send_request(route_request(32'h0000_0000, 8'd0));
        send_request(route_request(32'hFFFF_FFFF, 8'd1));
        send_request(route_request(32'h0A00_0001, 8'd2));
        send_request(route_request(32'h1234_5678, 8'd255));
    endtask

    // Nested prefixes, default route, clamped length, overwrites, hop rules.
    task automatic test_prefix_match();
        // default route: prefix bits are dropped by the zero-length mask
        send_request(add_request(32'h1234_5678, 6'd0, 1'b0, $urandom, 3'd1));
        send_request(add_request(32'h0A12_3456, 6'd8, 1'b1, 32'hC0A8_0001, 3'd2));
        send_request(add_request(32'h0A01_FFFF, 6'd16, 1'b0, 32'h0, 3'd3));
        // length above 32 behaves as a host route
        send_request(add_request(32'h0A01_0203, 6'd63, 1'b1, 32'hFFFF_FFFF, 3'd7));
        send_request(add_request(32'hFFFF_FFFF, 6'd32, 1'b1, 32'h0000_0000, 3'd6));
        send_request(add_request(32'h8000_0000, 6'd1, 1'b1, 32'h5555_AAAA, 3'd5));
        send_request(route_request(32'h0A01_0203, 8'd255));  // host route
        send_request(route_request(32'h0A01_0204, 8'd2));    // /16, ttl down to 1
        send_request(route_request(32'h0A02_0000, 8'd64));   // /8 with hop
        send_request(route_request(32'hFFFF_FFFF, 8'd128));  // all-ones host
        send_request(route_request(32'hFFFF_FFFE, 8'd10));   // /1
        send_request(route_request(32'h7000_0000, 8'd3));    // default only
        send_request(route_request(32'h0A01_0203, 8'd1));    // expires
        // same /8 with other low bits: overwrites, now without hop
        send_request(add_request(32'h0AFF_FFFF, 6'd8, 1'b0, 32'h0, 3'd0));
        send_request(route_request(32'h0A7F_0001, 8'd200));
        // overwrite the host route through a clamped length
        send_request(add_request(32'h0A01_0203, 6'd33, 1'b0, 32'h0, 3'd3));
        send_request(route_request(32'h0A01_0203, 8'd100));
    endtask

    // Response side stalls for a long stretch while requests keep coming,
    // so the output register fills and the request side backs up.
    task automatic test_backpressure();
        no_idle = 1'b1;
        hold_off_req = 1'b1;
        repeat (10) send_request(random_request());
        no_idle = 1'b0;
    endtask

    // Random traffic with an idle-free burst of 40 requests in every 160
    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++)
        begin
            no_idle = ((n / 40) % 4) == 3;
            send_request(random_request());
        end
        no_idle = 1'b0;
    endtask

    // Fills every entry with distinct host routes until adds are refused,
    // then checks that an overwrite still works on a full table.
    task automatic test_table_full();
        route_key_t key;
        for (int i = 0; i <= DEPTH; i++)
            send_request(add_request(32'hE000_0000 + i, 6'd32, 1'b1, $urandom,
                                     lrt_pkg::PORT_W'(i)));
        key = known_routes[0];
        send_request(add_request(key.prefix, lrt_pkg::LEN_W'(key.len), 1'b1,
                                 32'hDEAD_BEEF, 3'd4));
        send_request(route_request(key.prefix, 8'd77));
        send_request(route_request(32'hE000_0000, 8'd9));
        send_request(route_request(32'hE000_0000 + DEPTH, 8'd9));
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        mismatches   = 0;
        for (int i = 0; i < DEPTH; i++)
            tbl_valid[i] = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        drain_results();
        test_prefix_match();
        drain_results();
        test_backpressure();
        drain_results();
        test_random_traffic(RANDOM_ITEMS);
        drain_results();
        test_table_full();
        drain_results();

        $display("Ran %0d requests: %0d added, %0d forwarded, %0d expired,",
                 requests_sent, status_seen[lrt_pkg::ST_ADDED],
                 status_seen[lrt_pkg::ST_FORWARDED], status_seen[lrt_pkg::ST_TTL_EXPIRED]);
        $display("%0d unrouted, %0d full; nested prefixes, overwrites, %0d-cycle stall.",
                 status_seen[lrt_pkg::ST_NO_ROUTE], status_seen[lrt_pkg::ST_TABLE_FULL],
                 HOLD_OFF_CYCLES);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("Timeout with %0d responses outstanding", pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/lrt_pkg.sv
rtl/lrt_req_if.sv
rtl/lrt_rsp_if.sv
rtl/lrt_ram.sv
rtl/lrt_cmp.sv
rtl/lpm_route_table.sv
tb/lpm_route_table_test.sv
